// File: hdl/hsva_pkg.sv
// ---------------------------------------------------------------------------
// hsva_pkg
// shared constants and register codes for the hsv pixel adjust block
// ---------------------------------------------------------------------------
package hsva_pkg;

   localparam int CH_BITS        = 8;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_IDX_BITS   = 2;
   localparam int FRAC_BITS      = 16;

   localparam int HUE_BITS_DEF       = 16;
   localparam int GAIN_FRAC_BITS_DEF = 8;

   // one in the saturation / value scale
   localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   localparam logic [CSR_DATA_BITS-1:0] HUE_OFFSET_RST = 16'd0;
   localparam logic [CSR_DATA_BITS-1:0] SAT_GAIN_RST   = 16'd256;
   localparam logic [CSR_DATA_BITS-1:0] VALUE_GAIN_RST = 16'd256;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HUE_OFFSET = 2'd0,
      CSR_SAT_GAIN   = 2'd1,
      CSR_VALUE_GAIN = 2'd2
   } csr_index_type;

endpackage

// File: hdl/hsv_pixel_adjust.sv
// depth: two long dividers of max(17, HUE_BITS+1) stages set the pipeline depth
// throughput: one pixel per cycle; all stages advance together, and the whole
//   pipe holds only while a result sits in the output register under rsp_stall
// reset: synchronous, clears all valid bits and loads the register defaults
// ---------------------------------------------------------------------------
// hsv_pixel_adjust
// per-pixel rgb -> hsv, hue rotate, saturation / value gain, hsv -> rgb
// ---------------------------------------------------------------------------
module hsv_pixel_adjust import hsva_pkg::*; #(
   parameter int HUE_BITS       = HUE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CH_BITS-1:0]       req_red_in,
   input  logic [CH_BITS-1:0]       req_green_in,
   input  logic [CH_BITS-1:0]       req_blue_in,
   input  logic [CH_BITS-1:0]       req_alpha_in,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CH_BITS-1:0]       rsp_red_out,
   output logic [CH_BITS-1:0]       rsp_green_out,
   output logic [CH_BITS-1:0]       rsp_blue_out,
   output logic [CH_BITS-1:0]       rsp_alpha_out,
   // register write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   // divider depth, enough quotient bits for both hue and saturation
   localparam int LAT = (HUE_BITS + 1 > FRAC_BITS + 1) ? HUE_BITS + 1 : FRAC_BITS + 1;
   localparam int HNW = LAT + 11;   // hue numerator width
   localparam int SNW = LAT + 8;    // saturation numerator width
   localparam logic [HUE_BITS:0] HUE_ONE = {1'b1, {HUE_BITS{1'b0}}};
   localparam logic [HUE_BITS+17:0] HUE_HALF = (HUE_BITS+18)'(HUE_ONE >> 1);
   localparam logic [33:0] GAIN_HALF = 34'(1) << (GAIN_FRAC_BITS - 1);
   localparam logic [34:0] HALF16 = 35'(32768);

   typedef enum logic [2:0] {
      SEC_RED_YEL, SEC_YEL_GRN, SEC_GRN_CYN, SEC_CYN_BLU, SEC_BLU_MAG, SEC_MAG_RED
   } sector_type;

   // what rides beside the dividers
   typedef struct packed {
      logic [FRAC_BITS:0] vv;
      logic               grey;
      logic               black;
      logic [CH_BITS-1:0] alpha;
   } side_type;

   // ---------------- configuration registers ----------------
   logic [CSR_DATA_BITS-1:0] hue_offset_ff, sat_gain_ff, value_gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_offset_ff <= HUE_OFFSET_RST;
         sat_gain_ff   <= SAT_GAIN_RST;
         value_gain_ff <= VALUE_GAIN_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_HUE_OFFSET: hue_offset_ff <= csr_data;
            CSR_SAT_GAIN:   sat_gain_ff   <= csr_data;
            CSR_VALUE_GAIN: value_gain_ff <= csr_data;
            default: ;   // unknown index, write dropped
         endcase
      end
   end

   // hue offset rescaled to HUE_BITS (left shift, or truncating right shift)
   logic [HUE_BITS+15:0] off_wide;
   logic [HUE_BITS-1:0]  off_scaled;
   assign off_wide   = {hue_offset_ff, {HUE_BITS{1'b0}}};
   assign off_scaled = off_wide[HUE_BITS+15:16];

   // ---------------- flow control ----------------
   // every stage moves together unless the output transaction is held
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---------------- stage 0: input register ----------------
   logic                v0_ff;
   logic [CH_BITS-1:0]  r0_ff, g0_ff, b0_ff, a0_ff;

   // ---------------- stage 1: extrema, hue sector numerator ----------------
   logic [CH_BITS-1:0] mx, mn, dd;
   logic [10:0]        d6, hn;
   logic [HNW-1:0]     hue_num_in;
   logic [SNW-1:0]     sat_num_in;
   logic [FRAC_BITS:0] vv_in;

   always_comb begin
      mx = (r0_ff > g0_ff) ? ((r0_ff > b0_ff) ? r0_ff : b0_ff)
                           : ((g0_ff > b0_ff) ? g0_ff : b0_ff);
      mn = (r0_ff < g0_ff) ? ((r0_ff < b0_ff) ? r0_ff : b0_ff)
                           : ((g0_ff < b0_ff) ? g0_ff : b0_ff);
      dd = mx - mn;
      d6 = 11'({dd, 2'b00}) + 11'({dd, 1'b0});
      // ties go red first, then green
      if (mx == r0_ff) begin
         hn = (g0_ff >= b0_ff) ? 11'(g0_ff - b0_ff) : d6 - 11'(b0_ff - g0_ff);
      end else if (mx == g0_ff) begin
         hn = 11'({dd, 1'b0}) + 11'(b0_ff) - 11'(r0_ff);
      end else begin
         hn = 11'({dd, 2'b00}) + 11'(r0_ff) - 11'(g0_ff);
      end
      // rounded quotients: add half the divisor
      hue_num_in = HNW'({hn, {HUE_BITS{1'b0}}}) + HNW'(11'({dd, 1'b0}) + 11'(dd));
      sat_num_in = SNW'({dd, 16'h0000}) + SNW'(mx >> 1);
      // round(mx * 65536 / 255) = mx * 257 + (mx >= 128)
      vv_in      = 17'({mx, mx}) + 17'(mx[CH_BITS-1]);
   end

   logic           v1_ff;
   logic [HNW-1:0] hue_num_ff;
   logic [10:0]    hue_den_ff;
   logic [SNW-1:0] sat_num_ff;
   logic [7:0]     sat_den_ff;
   side_type       sd1_ff;

   // ---------------- dividers ----------------
   logic [LAT-1:0] hue_quo, sat_quo;

   hsva_div_pipe #(.QW(LAT), .DW(11)) u_hue_div (
      .clock  (clock),
      .enable (advance),
      .num    (hue_num_ff),
      .den    (hue_den_ff),
      .quo    (hue_quo)
   );

   hsva_div_pipe #(.QW(LAT), .DW(8)) u_sat_div (
      .clock  (clock),
      .enable (advance),
      .num    (sat_num_ff),
      .den    (sat_den_ff),
      .quo    (sat_quo)
   );

   logic     dv_ff [LAT];
   side_type sb_ff [LAT];

   // ---------------- stage 2: hue rotate, gain products ----------------
   logic [HUE_BITS-1:0] hv_in;
   logic [FRAC_BITS:0]  sv_sel;
   logic [32:0]         svm_in, vvm_in;

   always_comb begin
      // grey pixels have hue zero; black pixels have saturation zero
      hv_in  = (sb_ff[LAT-1].grey ? '0 : hue_quo[HUE_BITS-1:0]) + off_scaled;
      sv_sel = sb_ff[LAT-1].black ? '0 : sat_quo[FRAC_BITS:0];
      svm_in = 33'(sv_sel) * 33'(sat_gain_ff);
      vvm_in = 33'(sb_ff[LAT-1].vv) * 33'(value_gain_ff);
   end

   logic                v2_ff;
   logic [HUE_BITS-1:0] hv2_ff;
   logic [32:0]         svm2_ff, vvm2_ff;
   logic [CH_BITS-1:0]  a2_ff;

   // ---------------- stage 3: gain round and clamp, sector split ----------------
   logic [33:0]         svr, vvr;
   logic [33:0]         svs, vvs;
   logic [HUE_BITS+2:0] hv6;
   logic [FRAC_BITS:0]  sv3_in, vv3_in;

   always_comb begin
      svr    = 34'(svm2_ff) + GAIN_HALF;
      vvr    = 34'(vvm2_ff) + GAIN_HALF;
      svs    = svr >> GAIN_FRAC_BITS;
      vvs    = vvr >> GAIN_FRAC_BITS;
      sv3_in = (svs > 34'(FRAC_ONE)) ? FRAC_ONE : 17'(svs);
      vv3_in = (vvs > 34'(FRAC_ONE)) ? FRAC_ONE : 17'(vvs);
      hv6    = ((HUE_BITS+3)'(hv2_ff) << 2) + ((HUE_BITS+3)'(hv2_ff) << 1);
   end

   logic                v3_ff;
   logic [FRAC_BITS:0]  sv3_ff, vv3_ff;
   logic [2:0]          i3_ff;
   logic [HUE_BITS-1:0] f3_ff;
   logic [CH_BITS-1:0]  a3_ff;

   // ---------------- stage 4: p product, fractional saturation products ----------------
   logic                v4_ff;
   logic [33:0]         pm4_ff;
   logic [HUE_BITS+17:0] fq4_ff, ft4_ff;
   logic [FRAC_BITS:0]  vv4_ff;
   logic [2:0]          i4_ff;
   logic [CH_BITS-1:0]  a4_ff;

   // ---------------- stage 5: round p and f*s terms ----------------
   logic [HUE_BITS+17:0] fqr, ftr;
   logic [34:0]          pr;
   always_comb begin
      fqr = fq4_ff + HUE_HALF;
      ftr = ft4_ff + HUE_HALF;
      pr  = 35'(pm4_ff) + HALF16;
   end

   logic               v5_ff;
   logic [FRAC_BITS:0] p5_ff, fq5_ff, ft5_ff, vv5_ff;
   logic [2:0]         i5_ff;
   logic [CH_BITS-1:0] a5_ff;

   // ---------------- stage 6: q and t products ----------------
   logic               v6_ff;
   logic [33:0]        qm6_ff, tm6_ff;
   logic [FRAC_BITS:0] p6_ff, vv6_ff;
   logic [2:0]         i6_ff;
   logic [CH_BITS-1:0] a6_ff;

   // ---------------- stage 7: round q and t ----------------
   logic [34:0] qr, tr;
   always_comb begin
      qr = 35'(qm6_ff) + HALF16;
      tr = 35'(tm6_ff) + HALF16;
   end

   logic               v7_ff;
   logic [FRAC_BITS:0] q7_ff, t7_ff, p7_ff, vv7_ff;
   logic [2:0]         i7_ff;
   logic [CH_BITS-1:0] a7_ff;

   // ---------------- output stage: six-sector select, scale to bytes ----------------
   logic [FRAC_BITS:0] c0, c1, c2;

   always_comb begin
      case (sector_type'(i7_ff))
         SEC_RED_YEL: begin c0 = vv7_ff; c1 = t7_ff;  c2 = p7_ff;  end
         SEC_YEL_GRN: begin c0 = q7_ff;  c1 = vv7_ff; c2 = p7_ff;  end
         SEC_GRN_CYN: begin c0 = p7_ff;  c1 = vv7_ff; c2 = t7_ff;  end
         SEC_CYN_BLU: begin c0 = p7_ff;  c1 = q7_ff;  c2 = vv7_ff; end
         SEC_BLU_MAG: begin c0 = t7_ff;  c1 = p7_ff;  c2 = vv7_ff; end
         default:     begin c0 = vv7_ff; c1 = p7_ff;  c2 = q7_ff;  end
      endcase
   end

   // round(x * 255 / 65536), saturated
   function automatic logic [CH_BITS-1:0] to_byte(input logic [FRAC_BITS:0] x);
      logic [24:0] s;
      logic [8:0]  r;
      s = (25'(x) << 8) - 25'(x) + 25'(32768);
      r = s[24:16];
      return r[8] ? 8'hff : r[7:0];
   endfunction

   logic               rv_ff;
   logic [CH_BITS-1:0] ro_ff, go_ff, bo_ff, ao_ff;

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         for (int k = 0; k < LAT; k++) begin
            dv_ff[k] <= 1'b0;
         end
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else if (advance) begin
         v0_ff    <= req_valid;
         v1_ff    <= v0_ff;
         dv_ff[0] <= v1_ff;
         for (int k = 1; k < LAT; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         v2_ff <= dv_ff[LAT-1];
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         rv_ff <= v7_ff;
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (advance) begin
         r0_ff <= req_red_in;
         g0_ff <= req_green_in;
         b0_ff <= req_blue_in;
         a0_ff <= req_alpha_in;

         hue_num_ff   <= hue_num_in;
         hue_den_ff   <= d6;
         sat_num_ff   <= sat_num_in;
         sat_den_ff   <= mx;
         sd1_ff.vv    <= vv_in;
         sd1_ff.grey  <= (dd == '0);
         sd1_ff.black <= (mx == '0);
         sd1_ff.alpha <= a0_ff;

         sb_ff[0] <= sd1_ff;
         for (int k = 1; k < LAT; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end

         hv2_ff  <= hv_in;
         svm2_ff <= svm_in;
         vvm2_ff <= vvm_in;
         a2_ff   <= sb_ff[LAT-1].alpha;

         sv3_ff <= sv3_in;
         vv3_ff <= vv3_in;
         i3_ff  <= hv6[HUE_BITS+2:HUE_BITS];
         f3_ff  <= hv6[HUE_BITS-1:0];
         a3_ff  <= a2_ff;

         pm4_ff <= 34'(vv3_ff) * 34'(FRAC_ONE - sv3_ff);
         fq4_ff <= (HUE_BITS+18)'(f3_ff) * (HUE_BITS+18)'(sv3_ff);
         ft4_ff <= (HUE_BITS+18)'(HUE_ONE - (HUE_BITS+1)'(f3_ff)) * (HUE_BITS+18)'(sv3_ff);
         vv4_ff <= vv3_ff;
         i4_ff  <= i3_ff;
         a4_ff  <= a3_ff;

         p5_ff  <= 17'(pr >> 16);
         fq5_ff <= 17'(fqr >> HUE_BITS);
         ft5_ff <= 17'(ftr >> HUE_BITS);
         vv5_ff <= vv4_ff;
         i5_ff  <= i4_ff;
         a5_ff  <= a4_ff;

         qm6_ff <= 34'(vv5_ff) * 34'(FRAC_ONE - fq5_ff);
         tm6_ff <= 34'(vv5_ff) * 34'(FRAC_ONE - ft5_ff);
         p6_ff  <= p5_ff;
         vv6_ff <= vv5_ff;
         i6_ff  <= i5_ff;
         a6_ff  <= a5_ff;

         q7_ff  <= 17'(qr >> 16);
         t7_ff  <= 17'(tr >> 16);
         p7_ff  <= p6_ff;
         vv7_ff <= vv6_ff;
         i7_ff  <= i6_ff;
         a7_ff  <= a6_ff;

         ro_ff <= to_byte(c0);
         go_ff <= to_byte(c1);
         bo_ff <= to_byte(c2);
         ao_ff <= a7_ff;
      end
   end

   assign rsp_valid     = rv_ff;
   assign rsp_red_out   = ro_ff;
   assign rsp_green_out = go_ff;
   assign rsp_blue_out  = bo_ff;
   assign rsp_alpha_out = ao_ff;

endmodule

// File: hdl/hsva_div_pipe.sv
// ---------------------------------------------------------------------------
// hsva_div_pipe
// pipelined restoring divider, one quotient bit per register stage
// ---------------------------------------------------------------------------
module hsva_div_pipe #(
   parameter int QW = 17,
   parameter int DW = 8
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [QW+DW-1:0] num,
   input  logic [DW-1:0]    den,
   output logic [QW-1:0]    quo
);

   // caller guarantees num / den < 2**QW
   logic [DW-1:0] rem_ff [QW-1];
   logic [QW-1:0] low_ff [QW-1];
   logic [DW-1:0] den_ff [QW-1];
   logic [QW-1:0] quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] low_src;
      logic [QW-1:0] quo_src;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_src = num[QW+DW-1:QW];
         assign low_src = num[QW-1:0];
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign low_src = low_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      assign trial  = {rem_src, low_src[QW-1]};
      assign ge     = trial >= {1'b0, den_src};
      assign rem_in = ge ? DW'(trial - {1'b0, den_src}) : DW'(trial);
      assign quo_in = {quo_src[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[k] <= quo_in;
         end
      end

      if (k < QW-1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= rem_in;
               low_ff[k] <= low_src << 1;
               den_ff[k] <= den_src;
            end
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

// File: hdl/hsva_checker.sv
// ---------------------------------------------------------------------------
// hsva_checker
// port-level checks on the hsv pixel adjust block, bound to the top level
// ---------------------------------------------------------------------------
module hsva_checker import hsva_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [CH_BITS-1:0] rsp_red_out,
   input logic [CH_BITS-1:0] rsp_green_out,
   input logic [CH_BITS-1:0] rsp_blue_out,
   input logic [CH_BITS-1:0] rsp_alpha_out
);

   // a held response transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_alpha_out))
      else $error("response changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // requests are held back only by a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall without output back-pressure");

   // once the response is taken the request side opens again
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall ##1 !rsp_stall |-> !req_stall)
      else $error("request stall persists after response taken");

endmodule

bind hsv_pixel_adjust hsva_checker u_hsva_checker (.*);
